// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, removed when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/tlic_pkg.sv -----
// ----------------------------------------------------------------------------
// tlic_pkg
// Shared constants and a saturating-increment helper for the two-level inclusive cache tag core.
// ----------------------------------------------------------------------------
package tlic_pkg;

  // default geometry of the tag stores
  localparam int FIRST_LINES_DEF  = 256;
  localparam int SECOND_LINES_DEF = 4096;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_BITS_DEF    = 32;

  // counter width
  localparam int COUNT_W = 32;

  // configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 5;

  localparam logic [CFG_IW-1:0] REG_BLOCK_BITS   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_FIRST_SIZE   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_SECOND_SIZE  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_FIRST_ASSOC  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SECOND_ASSOC = 3'd4;
  localparam logic [CFG_IW-1:0] REG_WRITE_ALLOC  = 3'd5;

  // register reset values
  localparam logic [3:0] BLOCK_BITS_RST   = 4'd4;
  localparam logic [4:0] FIRST_SIZE_RST   = 5'd12;
  localparam logic [4:0] SECOND_SIZE_RST  = 5'd16;
  localparam logic [1:0] FIRST_ASSOC_RST  = 2'd1;
  localparam logic [1:0] SECOND_ASSOC_RST = 2'd2;
  localparam logic       WRITE_ALLOC_RST  = 1'b1;

  // access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // saturating increment of a counter
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

// ----- rtl/two_level_inclusive_cache_lru_core.sv -----
// ----------------------------------------------------------------------------
// two_level_inclusive_cache_lru_core
// Inclusive two-level write-back tag store with per-set age-counter LRU.
// ----------------------------------------------------------------------------
// Usage:
//   An item (command, address) is taken at a clock edge with start high and
//   busy low. busy stays high while the item is worked on; one result item
//   (hit flags and saturating access / miss counts) is shown for exactly one
//   cycle with done high, and busy drops the cycle after.
//   Each level keeps one tag memory with one read and one write port; all set
//   work goes through one way buffer per level, one way per cycle. A set load
//   reads every way of that level into the buffer and a store writes every way
//   back. On an L1 hit done follows the store of the L1 set; on an L2 miss the
//   path may add a back-invalidate and a dirty write-back, on an L2 hit a
//   write-back.
//   Configuration writes use cfg_valid/cfg_index/cfg_data; cfg_ready is always
//   high. Write registers only while the block is idle.
//   Reset: counters and registers return to their defaults, then a clearing
//   pass over max(FIRST_LINES, SECOND_LINES) addresses (4096 by default) zeroes
//   the valid, dirty and age fields; busy is high during it.
//   The receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_level_inclusive_cache_lru_core #(
  parameter int FIRST_LINES  = tlic_pkg::FIRST_LINES_DEF,
  parameter int SECOND_LINES = tlic_pkg::SECOND_LINES_DEF,
  parameter int MAX_WAYS     = tlic_pkg::MAX_WAYS_DEF,
  parameter int ADDR_BITS    = tlic_pkg::ADDR_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command,
  input  logic [ADDR_BITS-1:0]         address,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tlic_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [tlic_pkg::CFG_DW-1:0]  cfg_data,
  output logic                         done,
  output logic                         first_hit,
  output logic                         second_hit,
  output logic [tlic_pkg::COUNT_W-1:0] access_count,
  output logic [tlic_pkg::COUNT_W-1:0] first_miss_count,
  output logic [tlic_pkg::COUNT_W-1:0] second_miss_count
);
  import tlic_pkg::*;

  // widths
  localparam int LOGMAX = $clog2(MAX_WAYS);
  localparam int L1LOG  = $clog2(FIRST_LINES);
  localparam int L2LOG  = $clog2(SECOND_LINES);
  localparam int WIW    = (LOGMAX > 0) ? LOGMAX : 1;
  localparam int AW     = WIW;
  localparam int L1IW   = (L1LOG > 0) ? L1LOG : 1;
  localparam int L2IW   = (L2LOG > 0) ? L2LOG : 1;
  localparam int SW     = (L1IW > L2IW) ? L1IW : L2IW;
  localparam int IXW    = SW + WIW;
  localparam int BW     = 2 * ADDR_BITS;
  localparam int EW     = 2 + AW + ADDR_BITS;
  localparam int CAP1   = (LOGMAX < L1LOG) ? LOGMAX : L1LOG;
  localparam int CAP2   = (LOGMAX < L2LOG) ? LOGMAX : L2LOG;
  localparam int MAXL   = (FIRST_LINES > SECOND_LINES) ? FIRST_LINES : SECOND_LINES;
  localparam int CW     = ($clog2(MAXL) > 0) ? $clog2(MAXL) : 1;

  // sequencer states
  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_LOAD  = 5'd2;
  localparam logic [4:0] S_STORE = 5'd3;
  localparam logic [4:0] S_P1    = 5'd4;
  localparam logic [4:0] S_P2    = 5'd5;
  localparam logic [4:0] S_P3    = 5'd6;
  localparam logic [4:0] S_P3B   = 5'd7;
  localparam logic [4:0] S_P4    = 5'd8;
  localparam logic [4:0] S_P4F   = 5'd9;
  localparam logic [4:0] S_P5    = 5'd10;
  localparam logic [4:0] S_P6    = 5'd11;
  localparam logic [4:0] S_P6B   = 5'd12;
  localparam logic [4:0] S_P7    = 5'd13;
  localparam logic [4:0] S_P8    = 5'd14;
  localparam logic [4:0] S_P9    = 5'd15;
  localparam logic [4:0] S_P10   = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  localparam logic LV_L1 = 1'b0;
  localparam logic LV_L2 = 1'b1;

  // set and tag helpers
  function automatic logic [SW-1:0] set_of(input logic [BW-1:0] blk, input logic [5:0] sb);
    logic [BW-1:0] m;
    m = ~({BW{1'b1}} << sb);
    return SW'(blk & m);
  endfunction

  function automatic logic [ADDR_BITS-1:0] tag_of(input logic [BW-1:0] blk,
                                                  input logic [5:0] sb);
    return ADDR_BITS'(blk >> sb);
  endfunction

  function automatic logic [BW-1:0] mk_blk(input logic [ADDR_BITS-1:0] tag,
                                           input logic [SW-1:0] set, input logic [5:0] sb);
    return (BW'(tag) << sb) | BW'(set);
  endfunction

  function automatic logic [IXW-1:0] mk_idx(input logic [SW-1:0] set, input logic [1:0] wl,
                                            input logic [WIW-1:0] way);
    return (IXW'(set) << wl) | IXW'(way);
  endfunction

  // lowest valid way with a matching tag: {hit, way}
  function automatic logic [WIW:0] find_way(input logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tags,
                                            input logic [MAX_WAYS-1:0] vld,
                                            input logic [ADDR_BITS-1:0] tag,
                                            input logic [WIW:0] nways);
    logic [WIW:0] res;
    res = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (i < int'(nways) && vld[i] && tags[i] == tag) res = {1'b1, WIW'(i)};
    end
    return res;
  endfunction

  // lowest invalid way, else lowest way of age zero, else way 0
  function automatic logic [WIW-1:0] pick_victim(input logic [MAX_WAYS-1:0] vld,
                                                 input logic [MAX_WAYS-1:0][AW-1:0] ages,
                                                 input logic [WIW:0] nways);
    logic [WIW-1:0] inv_w;
    logic [WIW-1:0] zero_w;
    logic           inv_f;
    inv_w  = '0;
    zero_w = '0;
    inv_f  = 1'b0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (i < int'(nways)) begin
        if (!vld[i]) begin
          inv_f = 1'b1;
          inv_w = WIW'(i);
        end
        if (ages[i] == '0) zero_w = WIW'(i);
      end
    end
    return inv_f ? inv_w : zero_w;
  endfunction

  // age update for a touched way
  function automatic logic [MAX_WAYS-1:0][AW-1:0] touch_ages(
      input logic [MAX_WAYS-1:0][AW-1:0] ages, input logic [MAX_WAYS-1:0] vld,
      input logic [WIW-1:0] w, input logic [WIW:0] nways);
    logic [MAX_WAYS-1:0][AW-1:0] res;
    logic [AW-1:0]               old;
    res = ages;
    old = ages[w];
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (i < int'(nways) && WIW'(i) != w && vld[i] && ages[i] > old && ages[i] != '0)
        res[i] = ages[i] - 1'b1;
    end
    res[w] = AW'(nways - 1'b1);
    return res;
  endfunction

  // configuration registers
  logic [3:0] offset_bits;
  logic [4:0] first_size;
  logic [4:0] second_size;
  logic [1:0] first_assoc;
  logic [1:0] second_assoc;
  logic       alloc_wr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits  <= BLOCK_BITS_RST;
      first_size   <= FIRST_SIZE_RST;
      second_size  <= SECOND_SIZE_RST;
      first_assoc  <= FIRST_ASSOC_RST;
      second_assoc <= SECOND_ASSOC_RST;
      alloc_wr     <= WRITE_ALLOC_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BLOCK_BITS:   offset_bits  <= cfg_data[3:0];
        REG_FIRST_SIZE:   first_size   <= cfg_data[4:0];
        REG_SECOND_SIZE:  second_size  <= cfg_data[4:0];
        REG_FIRST_ASSOC:  first_assoc  <= cfg_data[1:0];
        REG_SECOND_ASSOC: second_assoc <= cfg_data[1:0];
        REG_WRITE_ALLOC:  alloc_wr     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // geometry of each level
  logic [1:0]        wl1, wl2;
  logic [WIW:0]      nw1, nw2;
  logic signed [7:0] sraw1, sraw2;
  logic [5:0]        lim1, lim2, sb1, sb2;

  always_comb begin
    wl1   = (first_assoc > CAP1) ? 2'(CAP1) : first_assoc;
    wl2   = (second_assoc > CAP2) ? 2'(CAP2) : second_assoc;
    nw1   = (WIW+1)'(1) << wl1;
    nw2   = (WIW+1)'(1) << wl2;
    sraw1 = $signed({3'b0, first_size}) - $signed({4'b0, offset_bits})
          - $signed({6'b0, first_assoc});
    sraw2 = $signed({3'b0, second_size}) - $signed({4'b0, offset_bits})
          - $signed({6'b0, second_assoc});
    lim1  = 6'(L1LOG) - {4'b0, wl1};
    lim2  = 6'(L2LOG) - {4'b0, wl2};
    sb1   = sraw1[7] ? 6'd0 : ((sraw1[5:0] > lim1) ? lim1 : sraw1[5:0]);
    sb2   = sraw2[7] ? 6'd0 : ((sraw2[5:0] > lim2) ? lim2 : sraw2[5:0]);
  end

  // sequencer and way buffers
  logic [4:0]     state;
  logic [4:0]     ls_ret;
  logic           ls_lvl;
  logic [SW-1:0]  ls_set;
  logic [WIW:0]   ls_cnt;
  logic [CW-1:0]  clr_cnt;

  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] a_tag, b_tag;
  logic [MAX_WAYS-1:0]                a_val, a_dty, b_val, b_dty;
  logic [MAX_WAYS-1:0][AW-1:0]        a_age, b_age;

  logic                 wr;
  logic [SW-1:0]        s1, s2;
  logic [ADDR_BITS-1:0] t1, t2, aux_tag;
  logic [BW-1:0]        tmp_blk;
  logic                 h2_hit;
  logic [WIW-1:0]       h2_way, v1, v2;
  logic [COUNT_W-1:0]   acc_cnt, miss1_cnt, miss2_cnt;
  logic                 hit1_r, hit2_r;

  logic [WIW:0]   fa, fb;
  logic [WIW-1:0] va, vb;
  logic [WIW:0]   ls_nw;
  logic [WIW-1:0] ls_prev;
  logic [BW-1:0]  in_blk;

  always_comb begin
    fa      = find_way(a_tag, a_val, (state == S_P1) ? t1 : aux_tag, nw1);
    fb      = find_way(b_tag, b_val, (state == S_P2) ? t2 : aux_tag, nw2);
    va      = pick_victim(a_val, a_age, nw1);
    vb      = pick_victim(b_val, b_age, nw2);
    ls_nw   = (ls_lvl == LV_L2) ? nw2 : nw1;
    ls_prev = WIW'(ls_cnt - 1'b1);
    in_blk  = BW'(address) >> offset_bits;
  end

  // tag memories
  logic [EW-1:0]   l1_mem [FIRST_LINES];
  logic [EW-1:0]   l2_mem [SECOND_LINES];
  logic [EW-1:0]   l1_rdata, l2_rdata, l1_wdata, l2_wdata;
  logic [L1IW-1:0] l1_raddr, l1_waddr;
  logic [L2IW-1:0] l2_raddr, l2_waddr;
  logic            l1_we, l2_we;
  logic [IXW-1:0]  idx1, idx2;
  logic [WIW-1:0]  cw;

  always_comb begin
    cw       = ls_cnt[WIW-1:0];
    idx1     = mk_idx(ls_set, wl1, cw);
    idx2     = mk_idx(ls_set, wl2, cw);
    l1_raddr = idx1[L1IW-1:0];
    l2_raddr = idx2[L2IW-1:0];
    if (state == S_CLEAR) begin
      l1_we    = (int'(clr_cnt) < FIRST_LINES);
      l2_we    = (int'(clr_cnt) < SECOND_LINES);
      l1_waddr = clr_cnt[L1IW-1:0];
      l2_waddr = clr_cnt[L2IW-1:0];
      l1_wdata = '0;
      l2_wdata = '0;
    end else begin
      l1_we    = (state == S_STORE) && (ls_lvl == LV_L1);
      l2_we    = (state == S_STORE) && (ls_lvl == LV_L2);
      l1_waddr = idx1[L1IW-1:0];
      l2_waddr = idx2[L2IW-1:0];
      l1_wdata = {a_val[cw], a_dty[cw], a_age[cw], a_tag[cw]};
      l2_wdata = {b_val[cw], b_dty[cw], b_age[cw], b_tag[cw]};
    end
  end

  always_ff @(posedge clk) begin
    if (l1_we) l1_mem[l1_waddr] <= l1_wdata;
    l1_rdata <= l1_mem[l1_raddr];
  end

  always_ff @(posedge clk) begin
    if (l2_we) l2_mem[l2_waddr] <= l2_wdata;
    l2_rdata <= l2_mem[l2_raddr];
  end

  // control sequence for one access
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      ls_cnt    <= '0;
      ls_lvl    <= LV_L1;
      ls_ret    <= S_IDLE;
      acc_cnt   <= '0;
      miss1_cnt <= '0;
      miss2_cnt <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (clr_cnt == CW'(MAXL - 1)) state <= S_IDLE;
          else clr_cnt <= clr_cnt + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            wr     <= (command == CMD_WRITE);
            s1     <= set_of(in_blk, sb1);
            t1     <= tag_of(in_blk, sb1);
            s2     <= set_of(in_blk, sb2);
            t2     <= tag_of(in_blk, sb2);
            ls_lvl <= LV_L1;
            ls_set <= set_of(in_blk, sb1);
            ls_cnt <= '0;
            ls_ret <= S_P1;
            state  <= S_LOAD;
          end
        end
        // read ways into the buffer, one per cycle
        S_LOAD: begin
          if (ls_cnt != '0) begin
            if (ls_lvl == LV_L1)
              {a_val[ls_prev], a_dty[ls_prev], a_age[ls_prev], a_tag[ls_prev]} <= l1_rdata;
            else
              {b_val[ls_prev], b_dty[ls_prev], b_age[ls_prev], b_tag[ls_prev]} <= l2_rdata;
          end
          if (ls_cnt == ls_nw) state <= ls_ret;
          else ls_cnt <= ls_cnt + 1'b1;
        end
        // write the buffer back, one way per cycle
        S_STORE: begin
          if (ls_cnt == ls_nw - 1'b1) state <= ls_ret;
          else ls_cnt <= ls_cnt + 1'b1;
        end
        // L1 lookup
        S_P1: begin
          acc_cnt <= sat_inc(acc_cnt);
          ls_cnt  <= '0;
          if (fa[WIW]) begin
            hit1_r <= 1'b1;
            hit2_r <= 1'b1;
            a_age  <= touch_ages(a_age, a_val, fa[WIW-1:0], nw1);
            if (wr) a_dty[fa[WIW-1:0]] <= 1'b1;
            ls_lvl <= LV_L1;
            ls_set <= s1;
            ls_ret <= S_DONE;
            state  <= S_STORE;
          end else begin
            hit1_r    <= 1'b0;
            miss1_cnt <= sat_inc(miss1_cnt);
            ls_lvl    <= LV_L2;
            ls_set    <= s2;
            ls_ret    <= S_P2;
            state     <= S_LOAD;
          end
        end
        // L2 lookup after an L1 miss
        S_P2: begin
          hit2_r <= fb[WIW];
          h2_hit <= fb[WIW];
          h2_way <= fb[WIW-1:0];
          ls_cnt <= '0;
          ls_lvl <= LV_L2;
          ls_set <= s2;
          if (fb[WIW]) b_age <= touch_ages(b_age, b_val, fb[WIW-1:0], nw2);
          else miss2_cnt <= sat_inc(miss2_cnt);
          if (wr && !alloc_wr) begin
            if (fb[WIW]) b_dty[fb[WIW-1:0]] <= 1'b1;
            ls_ret <= S_DONE;
            state  <= S_STORE;
          end else if (fb[WIW]) begin
            ls_ret <= S_P5;
            state  <= S_STORE;
          end else begin
            v2    <= vb;
            state <= S_P3;
          end
        end
        // L2 victim: rebuild its block when valid
        S_P3: begin
          if (b_val[v2]) begin
            tmp_blk <= mk_blk(b_tag[v2], s2, sb2);
            state   <= S_P3B;
          end else begin
            state <= S_P4F;
          end
        end
        S_P3B: begin
          aux_tag <= tag_of(tmp_blk, sb1);
          ls_lvl  <= LV_L1;
          ls_set  <= set_of(tmp_blk, sb1);
          ls_cnt  <= '0;
          ls_ret  <= S_P4;
          state   <= S_LOAD;
        end
        // back-invalidate the L1 copy
        S_P4: begin
          if (fa[WIW]) begin
            a_val[fa[WIW-1:0]] <= 1'b0;
            ls_cnt <= '0;
            ls_ret <= S_P4F;
            state  <= S_STORE;
          end else begin
            state <= S_P4F;
          end
        end
        // fill L2
        S_P4F: begin
          b_tag[v2] <= t2;
          b_val[v2] <= 1'b1;
          b_dty[v2] <= 1'b0;
          b_age     <= touch_ages(b_age, b_val, v2, nw2);
          ls_lvl    <= LV_L2;
          ls_set    <= s2;
          ls_cnt    <= '0;
          ls_ret    <= S_P5;
          state     <= S_STORE;
        end
        S_P5: begin
          ls_lvl <= LV_L1;
          ls_set <= s1;
          ls_cnt <= '0;
          ls_ret <= S_P6;
          state  <= S_LOAD;
        end
        // L1 victim: dirty lines write back
        S_P6: begin
          v1 <= va;
          if (a_val[va] && a_dty[va]) begin
            tmp_blk <= mk_blk(a_tag[va], s1, sb1);
            state   <= S_P6B;
          end else begin
            state <= S_P8;
          end
        end
        S_P6B: begin
          aux_tag <= tag_of(tmp_blk, sb2);
          ls_lvl  <= LV_L2;
          ls_set  <= set_of(tmp_blk, sb2);
          ls_cnt  <= '0;
          ls_ret  <= S_P7;
          state   <= S_LOAD;
        end
        S_P7: begin
          if (fb[WIW]) begin
            b_age              <= touch_ages(b_age, b_val, fb[WIW-1:0], nw2);
            b_dty[fb[WIW-1:0]] <= 1'b1;
            ls_cnt             <= '0;
            ls_ret             <= S_P8;
            state              <= S_STORE;
          end else begin
            state <= S_P8;
          end
        end
        // fill L1
        S_P8: begin
          a_tag[v1] <= t1;
          a_val[v1] <= 1'b1;
          a_dty[v1] <= wr;
          a_age     <= touch_ages(a_age, a_val, v1, nw1);
          ls_lvl    <= LV_L1;
          ls_set    <= s1;
          ls_cnt    <= '0;
          ls_ret    <= S_P9;
          state     <= S_STORE;
        end
        // second refresh of the L2 way that hit
        S_P9: begin
          if (h2_hit) begin
            ls_lvl <= LV_L2;
            ls_set <= s2;
            ls_cnt <= '0;
            ls_ret <= S_P10;
            state  <= S_LOAD;
          end else begin
            state <= S_DONE;
          end
        end
        S_P10: begin
          b_age  <= touch_ages(b_age, b_val, h2_way, nw2);
          ls_cnt <= '0;
          ls_ret <= S_DONE;
          state  <= S_STORE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // result ports
  assign busy              = (state != S_IDLE);
  assign done              = (state == S_DONE);
  assign first_hit         = hit1_r;
  assign second_hit        = hit2_r;
  assign access_count      = acc_cnt;
  assign first_miss_count  = miss1_cnt;
  assign second_miss_count = miss2_cnt;

  // checks
  `ASSERT_NXT(a_done_pulse, clk, rst, done, !done)
  `ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMP(a_hit_order, clk, rst, done && first_hit, second_hit)
  `ASSERT_IMP(a_miss_order, clk, rst, done, second_miss_count <= first_miss_count)

endmodule
